// ===== hw/rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  // Field widths of the stream items
  localparam int CMD_W        = 2;
  localparam int SYMBOL_W     = 8;
  localparam int CODE_FIELD_W = 32;
  localparam int LEN_FIELD_W  = 6;
  localparam int S_TDATA_W    = 48;   // symbol + code_bits + code_len, whole bytes
  localparam int BYTE_W       = 8;

  // Packer residue: at most seven bits wait between items
  localparam int PEND_W       = 7;
  localparam int PEND_CNT_W   = 3;

  // Trailer byte sent when a flush finds the packer empty
  localparam logic [BYTE_W-1:0] EMPTY_TRAILER = 8'd8;

  // Parameter defaults
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int NUM_SYMBOLS_DEF  = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT,
    ST_FL_DATA,
    ST_FL_CNT
  } state_e;

  typedef enum logic {
    OUT_ACC,
    OUT_CNT
  } out_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     mem_wr;
    logic     mem_rd;
    logic     merge;
    logic     shift;
    logic     clear;
    out_sel_e out_sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sym_ok;
    logic merge_has_byte;
    logic emit_last;
    logic pend_nz;
  } dp_stat_t;

endpackage : hcbp_pkg

`default_nettype wire

// ===== hw/rtl/hcbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcbp_ctrl
// Sequencer: decodes commands and steps the datapath through lookup,
// merge, byte emission and trailer emission.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ctrl
  import hcbp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  input  wire logic [CMD_W-1:0] s_cmd_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  output logic                  m_last_o,
  input  wire logic             m_ready_i,
  output dp_cmd_t               dp_cmd_o,
  input  wire dp_stat_t         dp_stat_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    s_ready_o        = 1'b0;
    m_valid_o        = 1'b0;
    m_last_o         = 1'b0;
    dp_cmd_o         = '0;
    dp_cmd_o.out_sel = OUT_ACC;

    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          case (s_cmd_i)
            CMD_LOAD: begin
              dp_cmd_o.mem_wr = dp_stat_i.sym_ok;
            end
            CMD_ENCODE: begin
              if (dp_stat_i.sym_ok) begin
                dp_cmd_o.mem_rd = 1'b1;
                state_d         = ST_MERGE;
              end
            end
            CMD_FLUSH: begin
              state_d = dp_stat_i.pend_nz ? ST_FL_DATA : ST_FL_CNT;
            end
            default: begin
              // drop the unused command
            end
          endcase
        end
      end

      ST_MERGE: begin
        dp_cmd_o.merge = 1'b1;
        state_d        = dp_stat_i.merge_has_byte ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        m_valid_o = 1'b1;
        m_last_o  = dp_stat_i.emit_last;
        if (m_ready_i) begin
          dp_cmd_o.shift = 1'b1;
          if (dp_stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_FL_DATA: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = ST_FL_CNT;
        end
      end

      ST_FL_CNT: begin
        m_valid_o        = 1'b1;
        m_last_o         = 1'b1;
        dp_cmd_o.out_sel = OUT_CNT;
        if (m_ready_i) begin
          dp_cmd_o.clear = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule : hcbp_ctrl

`default_nettype wire

// ===== hw/rtl/hcbp_datapath.sv =====
// ----------------------------------------------------------------------------
// hcbp_datapath
// Code table memory, bit accumulator and output byte selection.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_datapath
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [S_TDATA_W-1:0] s_data_i,
  output logic      [BYTE_W-1:0]    m_data_o,
  input  wire dp_cmd_t              dp_cmd_i,
  output dp_stat_t                  dp_stat_o
);

  // Longest code that can ever be emitted
  localparam int LenLimit = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int LenW     = $clog2(LenLimit + 1);
  localparam int AddrW    = $clog2(NUM_SYMBOLS);
  localparam int AccW     = PEND_W + LenLimit;
  localparam int TotW     = $clog2(AccW + 1);

  logic [SYMBOL_W-1:0]     symbol;
  logic [CODE_FIELD_W-1:0] code_bits;
  logic [LEN_FIELD_W-1:0]  code_len;
  logic [AddrW-1:0]        addr;
  logic [LenW-1:0]         len_sat;

  assign symbol    = s_data_i[SYMBOL_W-1:0];
  assign code_bits = s_data_i[SYMBOL_W +: CODE_FIELD_W];
  assign code_len  = s_data_i[SYMBOL_W + CODE_FIELD_W +: LEN_FIELD_W];
  assign addr      = symbol[AddrW-1:0];

  assign len_sat = (32'(code_len) > 32'(LenLimit)) ? LenW'(LenLimit) : LenW'(code_len);

  // Code table
  logic [LenLimit-1:0] code_mem [NUM_SYMBOLS];
  logic [LenW-1:0]     len_mem  [NUM_SYMBOLS];
  logic [LenLimit-1:0] rd_code_q;
  logic [LenW-1:0]     rd_len_q;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.mem_wr) begin
      code_mem[addr] <= code_bits[LenLimit-1:0];
      len_mem[addr]  <= len_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.mem_rd) begin
      rd_code_q <= code_mem[addr];
      rd_len_q  <= len_mem[addr];
    end
  end

  // Accumulator: low bits are the pending residue while idle
  logic [AccW-1:0]     acc_q, acc_d;
  logic [TotW-1:0]     tot_q, tot_d;
  logic [LenLimit-1:0] masked;
  logic [AccW-1:0]     merged;
  logic [TotW-1:0]     tot_m;

  always_comb begin
    for (int i = 0; i < LenLimit; i++) begin
      masked[i] = rd_code_q[i] & (32'(rd_len_q) > i);
    end
  end

  assign merged = AccW'(acc_q[PEND_W-1:0]) | (AccW'(masked) << tot_q[PEND_CNT_W-1:0]);
  assign tot_m  = TotW'(tot_q[PEND_CNT_W-1:0]) + TotW'(rd_len_q);

  always_comb begin
    acc_d = acc_q;
    tot_d = tot_q;
    if (dp_cmd_i.clear) begin
      acc_d = '0;
      tot_d = '0;
    end else if (dp_cmd_i.merge) begin
      acc_d = merged;
      tot_d = tot_m;
    end else if (dp_cmd_i.shift) begin
      acc_d = acc_q >> BYTE_W;
      tot_d = tot_q - TotW'(BYTE_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      tot_q <= '0;
    end else begin
      acc_q <= acc_d;
      tot_q <= tot_d;
    end
  end

  always_comb begin
    case (dp_cmd_i.out_sel)
      OUT_ACC: m_data_o = acc_q[BYTE_W-1:0];
      OUT_CNT: m_data_o = dp_stat_o.pend_nz ? BYTE_W'(tot_q[PEND_CNT_W-1:0]) : EMPTY_TRAILER;
      default: m_data_o = acc_q[BYTE_W-1:0];
    endcase
  end

  assign dp_stat_o.sym_ok         = ({1'b0, symbol} < (SYMBOL_W + 1)'(NUM_SYMBOLS));
  assign dp_stat_o.merge_has_byte = (32'(tot_m) >= 32'(BYTE_W));
  assign dp_stat_o.emit_last      = (32'(tot_q) < 32'(2 * BYTE_W));
  assign dp_stat_o.pend_nz        = (tot_q != '0);

endmodule : hcbp_datapath

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer_top.sv =====
// Sequence: a load is written to the table on acceptance; an encode reads the table,
//   merges, then emits one output byte per cycle while m_axis_tready_i is high (0 to 4
//   bytes); a flush emits 1 or 2 trailer bytes. One item is in flight at a time: no new
//   input is taken until the current item has finished its output bytes.
// Reset: rst_ni clears the sequencer and the packer residue; the code table is not
//   cleared and an entry must be loaded before its symbol is encoded.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Huffman encoder back end: code table and LSB-first byte packer with a
// flush trailer (partial byte and valid-bit count).
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_top
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,  // 1 .. 64, capped at 32 by the code field
  parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF    // 2 .. 256 table entries
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // Input transactions
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_len, [47:46] zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [CMD_W-1:0]     s_axis_tuser_i,

  // Output transactions
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [7:0] out_byte
  output logic      [BYTE_W-1:0]    m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer: accepts one transaction, then for an encode or flush walks merge/emit or trailer states
  hcbp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_cmd_i   (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_last_o  (m_axis_tlast_o),
    .m_ready_i (m_axis_tready_i),
    .dp_cmd_o  (dp_cmd),
    .dp_stat_i (dp_stat)
  );

  // Datapath: table memory, accumulator, output byte mux
  hcbp_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_data_i  (s_axis_tdata_i),
    .m_data_o  (m_axis_tdata_o),
    .dp_cmd_i  (dp_cmd),
    .dp_stat_o (dp_stat)
  );

  // One item at a time: never take input while a byte is on offer
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input accepted while output pending");

  // The trailer count byte is always 1 to 8
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && dp_cmd.out_sel == OUT_CNT) |->
      (m_axis_tdata_o != 8'd0 && m_axis_tdata_o <= EMPTY_TRAILER))
    else $error("trailer count out of range");

  // Delivering the final byte of a run returns the block to accepting input
  a_last_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("block not ready after final byte");

  // A flush leaves the packer empty
  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && dp_cmd.out_sel == OUT_CNT) |=> !dp_stat.pend_nz)
    else $error("packer not cleared by flush");

endmodule : huffman_code_bit_packer_top

`default_nettype wire
